@@ design/assert_macros.svh @@
// Assertion helpers shared by the level meter modules.
// Both expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define SVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define SVM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

@@ design/svm_pkg.sv @@
package svm_pkg;

  // Defaults for the top level parameters
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int MAX_BUFFER_LEN_DEF = 4096;

  // Buffer length register
  localparam int             CFG_W        = 13;
  localparam logic [CFG_W-1:0] BUFLEN_RESET = 13'd256;

  // Full scale (1.0) in Q3.20
  localparam int ONE_Q = 1 << 20;

  // Input opcodes, carried on tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Per-channel accumulator control
  typedef struct packed {
    logic acc;   // sample beat taken this cycle
    logic last;  // that beat closes the buffer
  } lane_ctl_t;

  // Divide / root unit control
  typedef struct packed {
    logic start;  // load sum and length, begin
    logic ack;    // result taken, return to idle
  } root_ctl_t;

endpackage

@@ design/stereo_vu_meter_top.sv @@
`include "assert_macros.svh"

// Throughput: one stereo beat per cycle while a buffer fills; a buffer's last beat
//   waits until the previous result has moved to the output register.
// Result path: a buffer's last beat is registered (last2_q), which starts the
//   bit-serial divider and then the square root; the result is loaded into the
//   output register once both channels are done and the output is free.
// Reset: running peaks and sums, held peaks, clip flag and control state clear; buffer_len = 256.
module stereo_vu_meter_top import svm_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int MAX_BUFFER_LEN = MAX_BUFFER_LEN_DEF,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((6 * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // buffer length register
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  // tdata: sample_left, sample_right
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  // tuser: opcode
  input  logic             s_axis_tuser,
  // tdata: peak_left, peak_right, held_left, held_right, rms_left,
  //        rms_right, clipped, zero pad
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int LEN_W   = $clog2(MAX_BUFFER_LEN + 1);
  localparam int SUM_RAW = 2 * SAMPLE_BITS - 1 + $clog2(MAX_BUFFER_LEN);
  localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;

  logic [CFG_W-1:0] len_cfg_q;
  logic [LEN_W-1:0] len_eff, cnt_q;
  logic             ends_next, beat, smp, clr, smp_last;
  logic             last2_q, be_full_q;
  lane_ctl_t        lane_ctl;
  root_ctl_t        root_ctl;

  logic [SAMPLE_BITS-1:0] pk_l, pk_r, held_l, held_r;
  logic [SUM_W-1:0]       sum_l, sum_r;
  logic [SAMPLE_BITS-1:0] hold_l_q, hold_r_q;
  logic                   clip_q, clip_new;

  logic [SAMPLE_BITS-1:0] snap_pk_l_q, snap_pk_r_q, snap_held_l_q, snap_held_r_q;
  logic                   snap_clip_q;
  logic                   done_l, done_r, load;
  logic [SAMPLE_BITS-1:0] rms_l, rms_r;
  logic                   m_valid_q;
  logic [OUT_W-1:0]       m_data_q;

  // Buffer length register and clamp to 1..MAX_BUFFER_LEN
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= BUFLEN_RESET;
    end else if (cfg_we_i) begin
      len_cfg_q <= cfg_wdata_i;
    end
  end

  assign len_eff = (len_cfg_q == '0) ? LEN_W'(1) :
                   (32'(len_cfg_q) > 32'(MAX_BUFFER_LEN)) ? LEN_W'(MAX_BUFFER_LEN) :
                   LEN_W'(len_cfg_q);

  // Input handshake: hold off a buffer-ending beat while the back end is taken
  assign ends_next     = ((LEN_W+1)'(cnt_q) + (LEN_W+1)'(1)) >= (LEN_W+1)'(len_eff);
  assign s_axis_tready = !ends_next || !(be_full_q || last2_q);
  assign beat          = s_axis_tvalid && s_axis_tready;
  assign smp           = beat && (s_axis_tuser == OP_SAMPLE);
  assign clr           = beat && (s_axis_tuser == OP_CLEAR);
  assign smp_last      = smp && ends_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      last2_q <= 1'b0;
    end else begin
      last2_q <= smp_last;
      if (smp) begin
        cnt_q <= smp_last ? '0 : (cnt_q + LEN_W'(1));
      end
    end
  end

  assign lane_ctl.acc  = smp;
  assign lane_ctl.last = ends_next;

  // Channel lanes
  svm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W)) u_lane_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lane_ctl),
    .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .peak_fin_o (pk_l),
    .sum_fin_o  (sum_l)
  );

  svm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W)) u_lane_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lane_ctl),
    .sample_i   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .peak_fin_o (pk_r),
    .sum_fin_o  (sum_r)
  );

  // Merge: held peaks and clip flag at buffer end
  always_comb begin
    held_l   = (pk_l > hold_l_q) ? pk_l : hold_l_q;
    held_r   = (pk_r > hold_r_q) ? pk_r : hold_r_q;
    clip_new = clip_q || (33'(pk_l) > 33'(ONE_Q)) || (33'(pk_r) > 33'(ONE_Q));
  end

  // A clear beat in the merge cycle arrived after the buffer's last beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_l_q <= '0;
      hold_r_q <= '0;
      clip_q   <= 1'b0;
    end else if (clr) begin
      hold_l_q <= '0;
      hold_r_q <= '0;
      clip_q   <= 1'b0;
    end else if (last2_q) begin
      hold_l_q <= held_l;
      hold_r_q <= held_r;
      clip_q   <= clip_new;
    end
  end

  // Snapshot held for the back end
  always_ff @(posedge clk_i) begin
    if (last2_q) begin
      snap_pk_l_q   <= pk_l;
      snap_pk_r_q   <= pk_r;
      snap_held_l_q <= held_l;
      snap_held_r_q <= held_r;
      snap_clip_q   <= clip_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      be_full_q <= 1'b0;
    end else if (last2_q) begin
      be_full_q <= 1'b1;
    end else if (load) begin
      be_full_q <= 1'b0;
    end
  end

  assign load           = be_full_q && done_l && done_r && (!m_valid_q || m_axis_tready);
  assign root_ctl.start = last2_q;
  assign root_ctl.ack   = load;

  // RMS back end, one per channel
  svm_root #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W), .LEN_W(LEN_W)) u_root_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (root_ctl),
    .sum_i  (sum_l),
    .len_i  (len_eff),
    .done_o (done_l),
    .root_o (rms_l)
  );

  svm_root #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W), .LEN_W(LEN_W)) u_root_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (root_ctl),
    .sum_i  (sum_r),
    .len_i  (len_eff),
    .done_o (done_r),
    .root_o (rms_r)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= OUT_W'({snap_clip_q, rms_r, rms_l, snap_held_r_q, snap_held_l_q,
                          snap_pk_r_q, snap_pk_l_q});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `SVM_ASSERT(a_roots_sync, (done_l == done_r), "channel root units out of step")
  `SVM_ASSERT(a_no_overrun, (last2_q |-> !be_full_q), "buffer end while back end occupied")
  `SVM_ASSERT_NEXT(a_snap_taken, last2_q, be_full_q && !done_l, "buffer end not handed off")
  `SVM_ASSERT(a_held_ge_peak, (be_full_q |-> (snap_held_l_q >= snap_pk_l_q) &&
                                (snap_held_r_q >= snap_pk_r_q)), "held peak below buffer peak")

endmodule

@@ design/svm_lane.sv @@
// One channel: magnitude and square in the first stage, peak and
// saturating sum-of-squares accumulation in the second.
module svm_lane import svm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_W       = 59
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lane_ctl_t                     ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic [SAMPLE_BITS-1:0]        peak_fin_o,
  output logic [SUM_W-1:0]              sum_fin_o
);

  logic [SAMPLE_BITS-1:0]   raw;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] sq;

  logic                     v_q, last_q;
  logic [SAMPLE_BITS-1:0]   mag_q;
  logic [2*SAMPLE_BITS-1:0] sq_q;
  logic [SAMPLE_BITS-1:0]   peak_q, peak_new;
  logic [SUM_W-1:0]         sum_q, sum_new;
  logic [SUM_W:0]           sum_ext;

  // Stage 1: magnitude (most negative code maps to 2^(N-1)) and square
  always_comb begin
    raw = sample_i;
    mag = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
    sq  = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      last_q <= 1'b0;
    end else begin
      v_q    <= ctl_i.acc;
      last_q <= ctl_i.acc & ctl_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      mag_q <= mag;
      sq_q  <= sq;
    end
  end

  // Stage 2: running peak and saturating sum
  always_comb begin
    peak_new = (mag_q > peak_q) ? mag_q : peak_q;
    sum_ext  = {1'b0, sum_q} + (SUM_W+1)'(sq_q);
    sum_new  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  end

  assign peak_fin_o = peak_new;
  assign sum_fin_o  = sum_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      sum_q  <= '0;
    end else if (v_q) begin
      if (last_q) begin
        peak_q <= '0;
        sum_q  <= '0;
      end else begin
        peak_q <= peak_new;
        sum_q  <= sum_new;
      end
    end
  end

endmodule

@@ design/svm_root.sv @@
`include "assert_macros.svh"

// Buffer-end back end for one channel: restoring divide of the sum by the
// buffer length (one quotient bit a cycle), then digit-by-digit integer
// square root (one root bit a cycle). Result holds until acknowledged.
module svm_root import svm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_W       = 59,
  parameter int LEN_W       = 13
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  root_ctl_t              ctl_i,
  input  logic [SUM_W-1:0]       sum_i,
  input  logic [LEN_W-1:0]       len_i,
  output logic                   done_o,
  output logic [SAMPLE_BITS-1:0] root_o
);

  localparam int RT_W  = (SUM_W + 1) / 2;
  localparam int RAD_W = 2 * RT_W;
  localparam int CNT_W = $clog2(SUM_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] step_q, step_d;

  logic [SUM_W-1:0] dq_q;
  logic [LEN_W-1:0] rem_q, div_q;
  logic [RAD_W-1:0] rad_q;
  logic [RT_W+1:0]  srem_q;
  logic [RT_W-1:0]  root_q;

  logic [LEN_W:0]   rem_sh, rem_nx;
  logic             qbit;
  logic [SUM_W-1:0] dq_nx;
  logic [RT_W+1:0]  srem_sh, trial, srem_nx;
  logic             rbit;

  // Divide step
  always_comb begin
    rem_sh = {rem_q, dq_q[SUM_W-1]};
    qbit   = (rem_sh >= {1'b0, div_q});
    rem_nx = qbit ? (rem_sh - {1'b0, div_q}) : rem_sh;
    dq_nx  = {dq_q[SUM_W-2:0], qbit};
  end

  // Root step: bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    srem_sh = {srem_q[RT_W-1:0], rad_q[RAD_W-1 -: 2]};
    trial   = {root_q, 2'b01};
    rbit    = (srem_sh >= trial);
    srem_nx = rbit ? (srem_sh - trial) : srem_sh;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          state_d = ST_DIV;
          step_d  = '0;
        end
      end
      ST_DIV: begin
        if (step_q == CNT_W'(SUM_W - 1)) begin
          state_d = ST_SQRT;
          step_d  = '0;
        end else begin
          step_d = step_q + CNT_W'(1);
        end
      end
      ST_SQRT: begin
        if (step_q == CNT_W'(RT_W - 1)) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (ctl_i.ack) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          dq_q  <= sum_i;
          div_q <= len_i;
          rem_q <= '0;
        end
      end
      ST_DIV: begin
        dq_q  <= dq_nx;
        rem_q <= rem_nx[LEN_W-1:0];
        if (step_q == CNT_W'(SUM_W - 1)) begin
          rad_q  <= RAD_W'(dq_nx);
          srem_q <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        srem_q <= srem_nx;
        root_q <= {root_q[RT_W-2:0], rbit};
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == ST_DONE);
  assign root_o = root_q[SAMPLE_BITS-1:0];

  `SVM_ASSERT(a_start_idle, (ctl_i.start |-> state_q == ST_IDLE), "root unit started while busy")

endmodule
